[rtl/shell_line_tokenizer_defines.svh]
// assertion macros shared by the tokenizer checker
`ifndef SHELL_LINE_TOKENIZER_DEFINES_SVH
`define SHELL_LINE_TOKENIZER_DEFINES_SVH

// checked outside reset only
`define SLT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define SLT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/slt_pkg.sv]
// types, character codes and helpers for the command line tokenizer
package slt_pkg;

   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam logic [1:0] KIND_PLAIN = 2'd0;
   localparam logic [1:0] KIND_SQ    = 2'd1;
   localparam logic [1:0] KIND_DQ    = 2'd2;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [7:0] token_char;
      logic       char_valid;
      logic [1:0] token_kind;
      logic       first_of_token;
      logic       last_of_token;
      logic       line_done;
   } rsp_beat_type;

   typedef struct packed {
      logic [1:0]   cnt;
      rsp_beat_type r0;
      rsp_beat_type r1;
   } beat_set_type;

   function automatic rsp_beat_type make_beat(input logic [7:0] ch, input logic [1:0] kind,
                                              input logic first, input logic last);
      rsp_beat_type b;
      b.token_char     = ch;
      b.char_valid     = 1'b1;
      b.token_kind     = kind;
      b.first_of_token = first;
      b.last_of_token  = last;
      b.line_done      = 1'b0;
      return b;
   endfunction

   function automatic beat_set_type add_beat(input beat_set_type set, input rsp_beat_type b);
      beat_set_type s;
      s = set;
      if (set.cnt == 2'd0) begin
         s.r0  = b;
         s.cnt = 2'd1;
      end else if (set.cnt == 2'd1) begin
         s.r1  = b;
         s.cnt = 2'd2;
      end
      return s;
   endfunction

endpackage

[rtl/slt_core.sv]
// scan state, held character and per-byte result logic
module slt_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            line_byte,
   input  logic                  end_of_line,
   output slt_pkg::beat_set_type beats
);

   localparam logic [2:0] MODE_BETWEEN = 3'd0;
   localparam logic [2:0] MODE_WORD    = 3'd1;
   localparam logic [2:0] MODE_SQ      = 3'd2;
   localparam logic [2:0] MODE_DQ      = 3'd3;
   localparam logic [2:0] MODE_LT      = 3'd4;
   localparam logic [2:0] MODE_GT      = 3'd5;

   logic [2:0] mode_ff, mode_in;
   logic [7:0] held_char_ff, held_char_in;
   logic       held_valid_ff, held_valid_in;
   logic       held_first_ff, held_first_in;
   logic [1:0] held_kind_ff, held_kind_in;

   always_comb begin
      slt_pkg::beat_set_type set;
      logic       is_sp;
      logic       go_start;
      logic       f;
      logic [7:0] q;
      logic [1:0] kd;
      logic [7:0] op;

      set           = '0;
      mode_in       = mode_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      held_first_in = held_first_ff;
      held_kind_in  = held_kind_ff;
      go_start      = 1'b0;
      f             = 1'b0;
      is_sp         = (line_byte == slt_pkg::CH_SPACE) ||
                      (line_byte >= slt_pkg::CH_TAB && line_byte <= slt_pkg::CH_CR);
      q             = (mode_ff == MODE_SQ) ? slt_pkg::CH_SQUOTE : slt_pkg::CH_DQUOTE;
      kd            = (mode_ff == MODE_SQ) ? slt_pkg::KIND_SQ : slt_pkg::KIND_DQ;
      op            = (mode_ff == MODE_LT) ? slt_pkg::CH_LT : slt_pkg::CH_GT;

      case (mode_ff)
         MODE_WORD: begin
            if (is_sp) begin
               if (held_valid_ff)
                  set = slt_pkg::add_beat(set, slt_pkg::make_beat(held_char_ff,
                                          held_kind_ff, held_first_ff, 1'b1));
               held_valid_in = 1'b0;
               mode_in       = MODE_BETWEEN;
            end else if (line_byte == slt_pkg::CH_EQ) begin
               if (held_valid_ff)
                  set = slt_pkg::add_beat(set, slt_pkg::make_beat(held_char_ff,
                                          held_kind_ff, held_first_ff, 1'b0));
               held_valid_in = 1'b0;
               set = slt_pkg::add_beat(set, slt_pkg::make_beat(line_byte,
                                       slt_pkg::KIND_PLAIN, 1'b0, 1'b1));
               mode_in = MODE_BETWEEN;
            end else begin
               if (held_valid_ff)
                  set = slt_pkg::add_beat(set, slt_pkg::make_beat(held_char_ff,
                                          held_kind_ff, held_first_ff, 1'b0));
               held_char_in  = line_byte;
               held_kind_in  = slt_pkg::KIND_PLAIN;
               held_first_in = 1'b0;
               held_valid_in = 1'b1;
            end
         end
         MODE_SQ, MODE_DQ: begin
            if (line_byte == q) begin
               if (held_valid_ff)
                  set = slt_pkg::add_beat(set, slt_pkg::make_beat(held_char_ff,
                                          held_kind_ff, held_first_ff, 1'b1));
               held_valid_in = 1'b0;
               mode_in       = MODE_BETWEEN;
            end else begin
               f = ~held_valid_ff;
               if (held_valid_ff)
                  set = slt_pkg::add_beat(set, slt_pkg::make_beat(held_char_ff,
                                          held_kind_ff, held_first_ff, 1'b0));
               held_char_in  = line_byte;
               held_kind_in  = kd;
               held_first_in = f;
               held_valid_in = 1'b1;
            end
         end
         MODE_LT, MODE_GT: begin
            if (line_byte == op) begin
               if (held_valid_ff)
                  set = slt_pkg::add_beat(set, slt_pkg::make_beat(held_char_ff,
                                          held_kind_ff, held_first_ff, 1'b0));
               held_valid_in = 1'b0;
               set = slt_pkg::add_beat(set, slt_pkg::make_beat(line_byte,
                                       slt_pkg::KIND_PLAIN, 1'b0, 1'b1));
               mode_in = MODE_BETWEEN;
            end else begin
               if (held_valid_ff)
                  set = slt_pkg::add_beat(set, slt_pkg::make_beat(held_char_ff,
                                          held_kind_ff, held_first_ff, 1'b1));
               held_valid_in = 1'b0;
               go_start      = 1'b1;
            end
         end
         default: begin
            held_valid_in = 1'b0;
            go_start      = 1'b1;
         end
      endcase

      // first byte after a gap, or after a lone < or >, decides what kind of token opens
      if (go_start) begin
         mode_in = MODE_BETWEEN;
         if (!is_sp) begin
            case (line_byte)
               slt_pkg::CH_SQUOTE: mode_in = MODE_SQ;
               slt_pkg::CH_DQUOTE: mode_in = MODE_DQ;
               slt_pkg::CH_PIPE, slt_pkg::CH_EQ: begin
                  set = slt_pkg::add_beat(set, slt_pkg::make_beat(line_byte,
                                          slt_pkg::KIND_PLAIN, 1'b1, 1'b1));
               end
               default: begin
                  held_char_in  = line_byte;
                  held_kind_in  = slt_pkg::KIND_PLAIN;
                  held_first_in = 1'b1;
                  held_valid_in = 1'b1;
                  if (line_byte == slt_pkg::CH_LT)
                     mode_in = MODE_LT;
                  else if (line_byte == slt_pkg::CH_GT)
                     mode_in = MODE_GT;
                  else
                     mode_in = MODE_WORD;
               end
            endcase
         end
      end

      if (end_of_line) begin
         if (held_valid_in)
            set = slt_pkg::add_beat(set, slt_pkg::make_beat(held_char_in,
                                    held_kind_in, held_first_in, 1'b1));
         held_valid_in = 1'b0;
         mode_in       = MODE_BETWEEN;
         if (set.cnt == 2'd0) begin
            set.r0           = '0;
            set.r0.line_done = 1'b1;
            set.cnt          = 2'd1;
         end else if (set.cnt == 2'd1) begin
            set.r0.line_done = 1'b1;
         end else begin
            set.r1.line_done = 1'b1;
         end
      end

      beats = set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_BETWEEN;
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
         held_first_ff <= 1'b0;
         held_kind_ff  <= slt_pkg::KIND_PLAIN;
      end else if (fire) begin
         mode_ff       <= mode_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         held_first_ff <= held_first_in;
         held_kind_ff  <= held_kind_in;
      end
   end

endmodule

[rtl/slt_rsp_queue.sv]
// small result queue taking up to two beats per cycle and giving one
module slt_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  slt_pkg::beat_set_type beats,
   input  logic                  pop,
   output slt_pkg::rsp_beat_type head,
   output logic                  not_empty,
   output logic                  room
);

   slt_pkg::rsp_beat_type entry_ff [slt_pkg::QDEPTH];

   logic [slt_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [slt_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [slt_pkg::QCNT_W-1:0] count_ff, count_in;
   logic [slt_pkg::QCNT_W-1:0] push_n;
   logic [slt_pkg::QPTR_W-1:0] wr_next;

   assign push_n    = push ? slt_pkg::QCNT_W'(beats.cnt) : '0;
   assign wr_next   = wr_ptr_ff + slt_pkg::QPTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + slt_pkg::QPTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + slt_pkg::QPTR_W'(pop);
   assign count_in  = count_ff + push_n - slt_pkg::QCNT_W'(pop);

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room      = (count_ff <= slt_pkg::QCNT_W'(slt_pkg::QDEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && beats.cnt != 2'd0)
         entry_ff[wr_ptr_ff] <= beats.r0;
      if (push && beats.cnt == 2'd2)
         entry_ff[wr_next] <= beats.r1;
   end

endmodule

[rtl/shell_line_tokenizer.sv]
// Command line tokenizer top level. One byte beat enters the input register per cycle
// unless req_stall holds it; the scan logic turns it into zero, one or two token character
// beats (a bare line-done beat when a line's last byte gives no character beat) in the same
// cycle it leaves the input register, and they wait in a four-entry result queue. A byte
// moves on when the queue has room for two beats, so bytes that give at most one beat
// each flow at one per cycle while the output is not stalled; a byte that gives two beats
// can make later bytes wait for room. The last character of a token appears one byte
// later than it arrived, once the token's end is known.
module shell_line_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_line_byte,
   input  logic       req_end_of_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_token_char,
   output logic       rsp_char_valid,
   output logic [1:0] rsp_token_kind,
   output logic       rsp_first_of_token,
   output logic       rsp_last_of_token,
   output logic       rsp_line_done
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eol_ff;
   logic       accept;
   logic       fire;
   logic       room;
   logic       pop;

   slt_pkg::beat_set_type beats;
   slt_pkg::rsp_beat_type head;

   assign fire        = in_valid_ff & room;
   assign req_stall   = in_valid_ff & ~fire;
   assign accept      = req_valid & ~req_stall;
   assign in_valid_in = accept | (in_valid_ff & ~fire);
   assign pop         = rsp_valid & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else
         in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_line_byte;
         in_eol_ff  <= req_end_of_line;
      end
   end

   slt_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .line_byte   (in_byte_ff),
      .end_of_line (in_eol_ff),
      .beats       (beats)
   );

   slt_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .beats     (beats),
      .pop       (pop),
      .head      (head),
      .not_empty (rsp_valid),
      .room      (room)
   );

   assign rsp_token_char     = head.token_char;
   assign rsp_char_valid     = head.char_valid;
   assign rsp_token_kind     = head.token_kind;
   assign rsp_first_of_token = head.first_of_token;
   assign rsp_last_of_token  = head.last_of_token;
   assign rsp_line_done      = head.line_done;

endmodule

[rtl/slt_checker.sv]
// port level checks for the command line tokenizer
`include "shell_line_tokenizer_defines.svh"

module slt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_token_char,
   input logic       rsp_char_valid,
   input logic [1:0] rsp_token_kind,
   input logic       rsp_first_of_token,
   input logic       rsp_last_of_token,
   input logic       rsp_line_done
);

   logic [14:0] rsp_word;
   logic        rsp_stalled;
   logic        bare_beat;
   logic        bare_ok;
   logic        kind_ok;
   logic        idle_ports;

   assign rsp_word    = {rsp_valid, rsp_token_char, rsp_char_valid, rsp_token_kind,
                         rsp_first_of_token, rsp_last_of_token, rsp_line_done};
   assign rsp_stalled = rsp_valid & rsp_stall;
   assign bare_beat   = rsp_valid & ~rsp_char_valid;
   assign bare_ok     = rsp_line_done && rsp_token_kind == slt_pkg::KIND_PLAIN &&
                        !rsp_first_of_token && !rsp_last_of_token &&
                        rsp_token_char == 8'd0;
   assign kind_ok     = rsp_token_kind == slt_pkg::KIND_PLAIN ||
                        rsp_token_kind == slt_pkg::KIND_SQ ||
                        rsp_token_kind == slt_pkg::KIND_DQ;
   assign idle_ports  = !rsp_valid && !req_stall;

   // stalled result beat keeps its payload
   `SLT_ASSERT(a_rsp_hold, clock, reset, rsp_stalled |=> $stable(rsp_word), "held beat changed")

   // bare beat only as the line-done marker
   `SLT_ASSERT(a_bare_beat, clock, reset, bare_beat |-> bare_ok, "bad line-done beat")

   // kind code three never leaves the block
   `SLT_ASSERT(a_kind_code, clock, reset, rsp_valid |-> kind_ok, "bad token kind")

   // nothing to deliver right after reset
   `SLT_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> idle_ports, "busy after reset")

endmodule

bind shell_line_tokenizer slt_checker u_checker (.*);
